@@ rtl/core/bhta_pkg.sv @@
// types and constants for the button hold trigger action block
// no dependencies

package bhta_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned ValueW = 16;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_INC    = 2'd1,
    ACT_DEC    = 2'd2,
    ACT_TOGGLE = 2'd3
  } action_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTION_KIND = 2'd0,
    REG_TRIG_REL    = 2'd1,
    REG_HOLD_MS     = 2'd2,
    REG_BOUND       = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    action_kind_e            action_kind;
    logic                    trigger_on_release;
    logic [HoldW-1:0]        hold_ms;
    logic [ValueW-1:0]       bound;
  } cfg_t;

  typedef struct packed {
    logic                    last_level;
    logic [TimeW-1:0]        press_start;
    logic                    fired;
  } state_t;

  typedef struct packed {
    logic                    pressed;
    logic [TimeW-1:0]        now_ms;
    logic [ValueW-1:0]       value_in;
  } sample_t;

  typedef struct packed {
    logic [ValueW-1:0]       value_out;
    logic                    claimed_set;
  } result_t;

endpackage

@@ rtl/core/bhta_core.sv @@
// hold decision and channel action for one sample
// depends on bhta_pkg

module bhta_core (
  input  bhta_pkg::cfg_t    cfg_i,
  input  bhta_pkg::state_t  state_i,
  input  bhta_pkg::sample_t sample_i,
  output bhta_pkg::state_t  state_o,
  output bhta_pkg::result_t result_o
);
  import bhta_pkg::*;

  logic             rise;
  logic [TimeW-1:0] start;
  logic             fired_base;
  logic [TimeW-1:0] elapsed;
  logic             hold_ok;
  logic             fire;
  logic [ValueW-1:0] v;
  logic [ValueW-1:0] acted;

  always_comb begin
    v          = sample_i.value_in;
    rise       = sample_i.pressed & ~state_i.last_level;
    start      = rise ? sample_i.now_ms : state_i.press_start;
    fired_base = rise ? 1'b0 : state_i.fired;
    elapsed    = sample_i.now_ms - start;
    hold_ok    = elapsed >= {{(TimeW-HoldW){1'b0}}, cfg_i.hold_ms};

    if (!cfg_i.trigger_on_release) begin
      fire = sample_i.pressed & ~fired_base & hold_ok;
    end else begin
      fire = ~sample_i.pressed & state_i.last_level & hold_ok;
    end

    state_o.last_level  = sample_i.pressed;
    state_o.press_start = start;
    if (fire) begin
      state_o.fired = 1'b1;
    end else if (!cfg_i.trigger_on_release && !sample_i.pressed) begin
      state_o.fired = 1'b0;
    end else begin
      state_o.fired = fired_base;
    end

    unique case (cfg_i.action_kind)
      ACT_SET:    acted = cfg_i.bound;
      ACT_INC:    acted = (v < cfg_i.bound) ? v + ValueW'(1) : v;
      ACT_DEC:    acted = (v > cfg_i.bound) ? v - ValueW'(1) : v;
      ACT_TOGGLE: acted = (v != '0) ? '0 : cfg_i.bound;
      default:    acted = v;
    endcase

    result_o.value_out   = fire ? acted : v;
    result_o.claimed_set = fire;
  end

endmodule

@@ rtl/core/button_hold_trigger_action.sv @@
// a sample passes the input register, then the result register, before its result is valid
// throughput: one sample per cycle, except that a full result register with the output stalled
// holds back the next sample; the hold state is updated as a sample leaves the input register
// reset (async, active low) clears the configuration registers, press state and both stage valids
// depends on bhta_pkg and bhta_core

module button_hold_trigger_action (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bhta_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bhta_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            pressed_i,
  input  logic [bhta_pkg::TimeW-1:0]      now_ms_i,
  input  logic [bhta_pkg::ValueW-1:0]     value_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bhta_pkg::ValueW-1:0]     value_out_o,
  output logic                            claimed_set_o
);
  import bhta_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  sample_t smp_q;
  logic    smp_valid_q;
  result_t res_q, res_d;
  logic    res_valid_q;
  logic    advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ACTION_KIND: cfg_q.action_kind <= action_kind_e'(cfg_data_i[1:0]);
        REG_TRIG_REL:    cfg_q.trigger_on_release <= cfg_data_i[0];
        REG_HOLD_MS:     cfg_q.hold_ms <= cfg_data_i[HoldW-1:0];
        REG_BOUND:       cfg_q.bound <= cfg_data_i[ValueW-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = smp_valid_q & (~res_valid_q | out_ready_i);
  assign in_ready_o = ~smp_valid_q | advance;

  bhta_core u_core (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .sample_i (smp_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      smp_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q.pressed  <= pressed_i;
      smp_q.now_ms   <= now_ms_i;
      smp_q.value_in <= value_in_i;
    end
  end

  // press state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign value_out_o   = res_q.value_out;
  assign claimed_set_o = res_q.claimed_set;

`ifndef ASSERT_OFF
  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled with result register free");

  a_fire_sets_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.claimed_set) |=> state_q.fired)
    else $error("fired flag not set after a trigger");

  a_rise_stores_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && smp_q.pressed && !state_q.last_level)
      |=> (state_q.press_start == $past(smp_q.now_ms)))
    else $error("press start not captured on rising edge");

  a_result_follows_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("result lost after stage advance");
`endif

endmodule
